// File: rtl/ddm_pkg.sv
// Shared constants, tables and types for the differential drive mixer.
// Used by every module in rtl/; depends on nothing.
package ddm_pkg;

    localparam int SQRT_STEPS   = 14;
    localparam int SERIES_TERMS = 12;
    localparam int CORDIC_STEPS = 16;

    localparam int LAT_SQRT     = SQRT_STEPS + 1;
    localparam int LAT_EXP      = 3 * (SERIES_TERMS - 1) + 2;
    localparam int LAT_CORDIC   = CORDIC_STEPS + 2;
    localparam int LAT_MIX      = 2;
    localparam int HEAD_DLY     = LAT_SQRT + LAT_EXP - LAT_CORDIC;
    localparam int LAT_TOTAL    = LAT_SQRT + LAT_EXP + LAT_MIX;

    localparam logic [14:0] ONE_Q14  = 15'd16384;
    localparam logic [31:0] MAG_SAT  = 32'd4194304;
    localparam logic [29:0] LN2_Q30  = 30'd744261118;

    localparam logic [15:0] ATAN_TAB [CORDIC_STEPS] = '{
        16'd32768, 16'd19344, 16'd10221, 16'd5188, 16'd2604, 16'd1303, 16'd652, 16'd326,
        16'd163,   16'd81,    16'd41,    16'd20,   16'd10,   16'd5,    16'd3,   16'd1
    };

    typedef struct packed {
        logic signed [15:0] heading;
        logic               pos;
    } ddm_heading_t;

endpackage

// File: rtl/differential_drive_mixer_core.sv
// Top level of the differential drive mixer: magnitude, speed, heading and mixing pipelines.
// Depends on ddm_pkg, ddm_mag_sqrt, ddm_speed_exp, ddm_heading_cordic, ddm_wheel_mix.
//
//  channel | signals                                   | direction
//  input   | in_valid, in_stall, linear/angular_command | command transfer in
//  output  | out_valid, out_stall, left/right_speed     | wheel speed transfer out
//
// One transfer per cycle while the output is not stalled. The path runs the 14-step root, the
// 11-term series at three stages per term, and mixing. The 18-stage CORDIC runs
// alongside and its heading is delayed through the hd_reg chain to meet the speed.
// Reset clears only the valid bits; no clearing pass.
// A stalled output holds the whole pipeline; in_stall follows at once.
module differential_drive_mixer_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] linear_command,
    input  logic signed [15:0] angular_command,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] left_speed,
    output logic signed [15:0] right_speed
);

    localparam int NL = ddm_pkg::LAT_TOTAL;
    localparam int ND = ddm_pkg::HEAD_DLY;

    logic                  en;
    logic [NL-1:0]         vld_reg;
    logic [NL-1:0]         vld_next;
    logic [14:0]           mag;
    logic [14:0]           speed;
    ddm_pkg::ddm_heading_t head;
    ddm_pkg::ddm_heading_t hd_reg [0:ND-1];

    assign en       = !(vld_reg[NL-1] && out_stall);
    assign in_stall = !en;
    assign out_valid = vld_reg[NL-1];
    assign vld_next = {vld_reg[NL-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    ddm_mag_sqrt u_sqrt (
        .clk             (clk),
        .en              (en),
        .linear_command  (linear_command),
        .angular_command (angular_command),
        .mag             (mag)
    );

    ddm_speed_exp u_exp (
        .clk   (clk),
        .en    (en),
        .mag   (mag),
        .speed (speed)
    );

    ddm_heading_cordic u_cordic (
        .clk             (clk),
        .en              (en),
        .linear_command  (linear_command),
        .angular_command (angular_command),
        .head            (head)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hd_reg[0] <= head;
            for (int i = 1; i < ND; i++)
            begin
                hd_reg[i] <= hd_reg[i-1];
            end
        end
    end

    ddm_wheel_mix u_mix (
        .clk         (clk),
        .en          (en),
        .speed       (speed),
        .head        (hd_reg[ND-1]),
        .left_speed  (left_speed),
        .right_speed (right_speed)
    );

endmodule

// File: rtl/ddm_mag_sqrt.sv
// Command magnitude: sum of squares, saturation at one, one root bit per stage.
// Depends on ddm_pkg.
module ddm_mag_sqrt (
    input  logic               clk,
    input  logic               en,
    input  logic signed [15:0] linear_command,
    input  logic signed [15:0] angular_command,
    output logic        [14:0] mag
);

    logic signed [31:0] lin_sq;
    logic signed [31:0] ang_sq;
    logic        [31:0] sum_sq;
    logic        [27:0] rem_reg  [0:ddm_pkg::SQRT_STEPS];
    logic        [27:0] root_reg [0:ddm_pkg::SQRT_STEPS];
    logic               sat_reg  [0:ddm_pkg::SQRT_STEPS];

    always_comb
    begin
        lin_sq = linear_command * linear_command;
        ang_sq = angular_command * angular_command;
        sum_sq = {1'b0, lin_sq[30:0]} + {1'b0, ang_sq[30:0]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sat_reg[0]  <= (sum_sq >= ddm_pkg::MAG_SAT);
            rem_reg[0]  <= {sum_sq[21:0], 6'b0};
            root_reg[0] <= 28'd0;
        end
    end

    for (genvar i = 0; i < ddm_pkg::SQRT_STEPS; i++)
    begin : g_step
        localparam logic [28:0] BIT = 29'd1 << (2 * (ddm_pkg::SQRT_STEPS - 1 - i));
        logic [28:0] trial;

        assign trial = {1'b0, root_reg[i]} + BIT;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sat_reg[i+1] <= sat_reg[i];
                if ({1'b0, rem_reg[i]} >= trial)
                begin
                    rem_reg[i+1]  <= 28'({1'b0, rem_reg[i]} - trial);
                    root_reg[i+1] <= 28'({2'b0, root_reg[i][27:1]} + BIT);
                end
                else
                begin
                    rem_reg[i+1]  <= rem_reg[i];
                    root_reg[i+1] <= {1'b0, root_reg[i][27:1]};
                end
            end
        end
    end

    assign mag = sat_reg[ddm_pkg::SQRT_STEPS] ? ddm_pkg::ONE_Q14
                                              : root_reg[ddm_pkg::SQRT_STEPS][14:0];

endmodule

// File: rtl/ddm_speed_exp.sv
// Speed shaping 2^m - 1 by a pipelined power series, three stages per term.
// Depends on ddm_pkg.
module ddm_speed_exp (
    input  logic        clk,
    input  logic        en,
    input  logic [14:0] mag,
    output logic [14:0] speed
);

    localparam int NT = ddm_pkg::SERIES_TERMS - 1;

    logic [44:0] t_prod;
    logic [29:0] t_reg    [0:NT];
    logic [29:0] term_reg [0:NT];
    logic [31:0] sum_reg  [0:NT];
    logic [32:0] rounded;
    logic [14:0] speed_reg;

    assign t_prod = mag * ddm_pkg::LN2_Q30;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg[0]    <= t_prod[43:14];
            term_reg[0] <= t_prod[43:14];
            sum_reg[0]  <= {2'b0, t_prod[43:14]};
        end
    end

    for (genvar j = 0; j < NT; j++)
    begin : g_term
        localparam logic [32:0] RECIP_W = (33'd1 << 32) / (j + 2);
        localparam logic [31:0] RECIP   = RECIP_W[31:0];
        localparam logic [3:0]  K       = 4'(j + 2);

        logic [59:0] mul_a;
        logic [61:0] mul_b;
        logic [33:0] qk;
        logic [29:0] rem;
        logic [29:0] a_v_reg;
        logic [29:0] a_t_reg;
        logic [31:0] a_sum_reg;
        logic [29:0] b_q0_reg;
        logic [29:0] b_v_reg;
        logic [29:0] b_t_reg;
        logic [31:0] b_sum_reg;
        logic [29:0] q;

        assign mul_a = term_reg[j] * t_reg[j];
        assign mul_b = a_v_reg * RECIP;
        assign qk    = b_q0_reg * K;
        assign rem   = b_v_reg - qk[29:0];
        assign q     = (rem >= 30'(K)) ? b_q0_reg + 30'd1 : b_q0_reg;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                a_v_reg     <= mul_a[59:30];
                a_t_reg     <= t_reg[j];
                a_sum_reg   <= sum_reg[j];
                b_q0_reg    <= mul_b[61:32];
                b_v_reg     <= a_v_reg;
                b_t_reg     <= a_t_reg;
                b_sum_reg   <= a_sum_reg;
                term_reg[j+1] <= q;
                t_reg[j+1]    <= b_t_reg;
                sum_reg[j+1]  <= b_sum_reg + {2'b0, q};
            end
        end
    end

    assign rounded = {1'b0, sum_reg[NT]} + 33'd32768;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (rounded[32:16] > 17'(ddm_pkg::ONE_Q14))
                speed_reg <= ddm_pkg::ONE_Q14;
            else
                speed_reg <= rounded[30:16];
        end
    end

    assign speed = speed_reg;

endmodule

// File: rtl/ddm_heading_cordic.sv
// Heading (2/pi)*atan2(angular, |linear|) by a vectoring CORDIC, one rotation per stage.
// Depends on ddm_pkg.
module ddm_heading_cordic (
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [15:0]    linear_command,
    input  logic signed [15:0]    angular_command,
    output ddm_pkg::ddm_heading_t head
);

    localparam int N = ddm_pkg::CORDIC_STEPS;

    logic        [16:0] ax;
    logic        [16:0] ay;
    logic signed [33:0] x_reg     [0:N];
    logic signed [33:0] y_reg     [0:N];
    logic signed [18:0] z_reg     [0:N];
    logic               azero_reg [0:N];
    logic               lzero_reg [0:N];
    logic               aneg_reg  [0:N];
    logic               pos_reg   [0:N];
    logic        [18:0] zc;
    logic        [18:0] hz;
    logic        [15:0] hmag;
    ddm_pkg::ddm_heading_t head_reg;

    always_comb
    begin
        ax = linear_command[15] ? 17'(-{linear_command[15], linear_command})
                                : {1'b0, linear_command};
        ay = angular_command[15] ? 17'(-{angular_command[15], angular_command})
                                 : {1'b0, angular_command};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]     <= {3'b0, ax, 14'b0};
            y_reg[0]     <= {3'b0, ay, 14'b0};
            z_reg[0]     <= 19'sd0;
            azero_reg[0] <= (angular_command == 16'sd0);
            lzero_reg[0] <= (linear_command == 16'sd0);
            aneg_reg[0]  <= angular_command[15];
            pos_reg[0]   <= (linear_command > 16'sd0);
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_rot
        logic signed [33:0] xs;
        logic signed [33:0] ys;
        logic signed [33:0] yneg;
        logic signed [18:0] ang;

        always_comb
        begin
            xs   = x_reg[i] >>> i;
            yneg = -y_reg[i];
            ys   = y_reg[i][33] ? -(yneg >>> i) : (y_reg[i] >>> i);
            ang  = signed'({3'b0, ddm_pkg::ATAN_TAB[i]});
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                azero_reg[i+1] <= azero_reg[i];
                lzero_reg[i+1] <= lzero_reg[i];
                aneg_reg[i+1]  <= aneg_reg[i];
                pos_reg[i+1]   <= pos_reg[i];
                if (y_reg[i] > 34'sd0)
                begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + ang;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - ang;
                end
            end
        end
    end

    always_comb
    begin
        zc   = z_reg[N][18] ? 19'd0 : z_reg[N];
        hz   = (zc + 19'd2) >> 2;
        hmag = (hz > 19'(ddm_pkg::ONE_Q14)) ? {1'b0, ddm_pkg::ONE_Q14} : hz[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            head_reg.pos <= pos_reg[N];
            if (azero_reg[N])
                head_reg.heading <= 16'sd0;
            else if (lzero_reg[N])
                head_reg.heading <= aneg_reg[N] ? -16'sd16384 : 16'sd16384;
            else
                head_reg.heading <= aneg_reg[N] ? -signed'(hmag) : signed'(hmag);
        end
    end

    assign head = head_reg;

endmodule

// File: rtl/ddm_wheel_mix.sv
// Quadrant mixing rules: scale one wheel by 1 +- 2*heading, round and saturate.
// Depends on ddm_pkg.
module ddm_wheel_mix (
    input  logic                  clk,
    input  logic                  en,
    input  logic [14:0]           speed,
    input  ddm_pkg::ddm_heading_t head,
    output logic signed [15:0]    left_speed,
    output logic signed [15:0]    right_speed
);

    logic signed [16:0] s;
    logic signed [17:0] h2;
    logic signed [17:0] f;
    logic signed [34:0] prod;
    logic signed [15:0] other;
    logic               on_left;
    logic signed [34:0] prod_reg;
    logic signed [15:0] other_reg;
    logic               on_left_reg;
    logic signed [34:0] rsum;
    logic signed [20:0] r;
    logic signed [15:0] scaled;
    logic signed [15:0] left_reg;
    logic signed [15:0] right_reg;

    always_comb
    begin
        s  = signed'({2'b0, speed});
        h2 = 18'(head.heading) <<< 1;
        if (head.heading > 16'sd0 && head.pos)
        begin
            f = 18'sd16384 - h2;  on_left = 1'b1; other = s[15:0];
        end
        else if (head.heading > 16'sd0)
        begin
            f = h2 - 18'sd16384;  on_left = 1'b0; other = -s[15:0];
        end
        else if (head.pos)
        begin
            f = 18'sd16384 + h2;  on_left = 1'b0; other = s[15:0];
        end
        else
        begin
            f = -18'sd16384 - h2; on_left = 1'b1; other = -s[15:0];
        end
        prod = f * s;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg    <= prod;
            other_reg   <= other;
            on_left_reg <= on_left;
        end
    end

    always_comb
    begin
        rsum = prod_reg + 35'sd8192;
        r    = 21'(rsum >>> 14);
        if (r > 21'sd16384)
            scaled = 16'sd16384;
        else if (r < -21'sd16384)
            scaled = -16'sd16384;
        else
            scaled = r[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            left_reg  <= on_left_reg ? scaled : other_reg;
            right_reg <= on_left_reg ? other_reg : scaled;
        end
    end

    assign left_speed  = left_reg;
    assign right_speed = right_reg;

endmodule
